>>> rtl/core/fps_pkg.sv
// Shared types and field widths for the Fenwick prefix-sum bank.
package fps_pkg;

	localparam int ACTION_W   = 1;
	localparam int SELECT_W   = 2;
	localparam int POSITION_W = 11;
	localparam int DELTA_W    = 32;
	localparam int SUM_W      = 64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD   = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/core/fps_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fps_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 3072
) (
	input  logic                     clk,
	input  logic                     wen,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/fenwick_prefix_sum_bank.sv
// Top level of the Fenwick prefix-sum bank: control, tree walk and output register.
// Each item walks k tree nodes, k <= log2(SIZE)+1, each as a RAM read (ST_READ) followed
// by an accumulate or write back (ST_UPDATE); a query then loads result_valid in ST_RESULT.
// One item is worked at a time: item_stall holds the next transfer until the walk ends
// and, for a query, until a stalled result has drained from the output register.
// After reset a clearing pass writes zero to all NUM_TREES*SIZE words, one per cycle.
module fenwick_prefix_sum_bank import fps_pkg::*; #(
	parameter int SIZE      = 1024,
	parameter int NUM_TREES = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [ACTION_W-1:0]     action,
	input  logic [SELECT_W-1:0]     tree_select,
	input  logic [POSITION_W-1:0]   position,
	input  logic signed [DELTA_W-1:0] delta,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic signed [SUM_W-1:0] prefix_sum
);

	localparam int DEPTH = NUM_TREES * SIZE;
	localparam int AW    = $clog2(DEPTH);
	// one extra bit so that the climb past SIZE still fits
	localparam int IW    = $clog2(SIZE + 1) + 1;
	localparam logic [IW-1:0] SIZE_IDX  = IW'(SIZE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	state_t state_q, state_d;

	logic [AW-1:0]    clr_addr_q;
	action_t          op_q;
	logic [IW-1:0]    idx_q;
	logic [AW-1:0]    base_q;
	logic [SUM_W-1:0] delta_q;
	logic [SUM_W-1:0] acc_q;
	logic             result_valid_q;
	logic [SUM_W-1:0] result_sum_q;

	// decode of the incoming item
	logic             item_xfer;
	logic [31:0]      pos_ext;
	logic             in_range;
	logic             tree_ok;
	logic             do_walk;
	logic [IW-1:0]    start_idx;

	// tree walk
	logic [IW-1:0]    low_bit;
	logic [IW-1:0]    idx_up;
	logic [IW-1:0]    idx_dn;
	logic [AW-1:0]    node_addr;
	logic [SUM_W-1:0] rd_data;

	// control strobes from the state machine
	logic             load_item;
	logic             step_node;
	logic             load_result;
	logic             ram_wen;
	logic             ram_ren;
	logic [AW-1:0]    ram_waddr;
	logic [SUM_W-1:0] ram_wdata;

	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;

	assign pos_ext   = 32'(position);
	assign in_range  = (pos_ext <= 32'(SIZE));
	assign tree_ok   = (32'(tree_select) < 32'(NUM_TREES));
	// a query beyond the tree saturates to the whole tree
	assign start_idx = in_range ? IW'(pos_ext) : SIZE_IDX;
	// an add outside the tree or at position zero touches nothing
	assign do_walk   = tree_ok && (position != '0) &&
		((action_t'(action) == ACT_QUERY) || in_range);

	// lowest set bit: climb for an add, descend for a query
	assign low_bit   = idx_q & (~idx_q + IW'(1));
	assign idx_up    = idx_q + low_bit;
	assign idx_dn    = idx_q - low_bit;
	assign node_addr = base_q + AW'(idx_q - IW'(1));

	always_comb begin
		state_d     = state_q;
		load_item   = 1'b0;
		step_node   = 1'b0;
		load_result = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_xfer) begin
					load_item = 1'b1;
					if (do_walk) begin
						state_d = ST_READ;
					end else if (action_t'(action) == ACT_QUERY) begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				step_node = 1'b1;
				if (op_q == ACT_QUERY) begin
					state_d = (idx_dn == '0) ? ST_RESULT : ST_READ;
				end else begin
					state_d = (idx_up > SIZE_IDX) ? ST_IDLE : ST_READ;
				end
			end
			ST_RESULT: begin
				// wait for the output register to drain
				if (!result_valid_q || !result_stall) begin
					load_result = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		if (load_item) begin
			op_q    <= action_t'(action);
			idx_q   <= start_idx;
			base_q  <= AW'(32'(tree_select) * 32'(SIZE));
			delta_q <= {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
			acc_q   <= '0;
		end else if (step_node) begin
			if (op_q == ACT_QUERY) begin
				acc_q <= acc_q + rd_data;
				idx_q <= idx_dn;
			end else begin
				idx_q <= idx_up;
			end
		end
		if (load_result) begin
			result_sum_q <= acc_q;
		end
	end

	// read the node, then accumulate or write it back; the clearing pass owns the write port
	assign ram_ren   = (state_q == ST_READ);
	assign ram_wen   = (state_q == ST_CLEAR) ||
		((state_q == ST_UPDATE) && (op_q == ACT_ADD));
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : node_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : (rd_data + delta_q);

	fps_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_sums (
		.clk   (clk),
		.wen   (ram_wen),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.ren   (ram_ren),
		.raddr (node_addr),
		.rdata (rd_data)
	);

	assign result_valid = result_valid_q;
	assign prefix_sum   = result_sum_q;

endmodule
